@@ src/twg_pkg.sv @@
// shared types and constants for the thermal window to gray block
package twg_pkg;

   localparam int unsigned RAW_W   = 16;
   localparam int unsigned GRAY_W  = 8;
   localparam int unsigned STEPS   = GRAY_W;
   localparam int unsigned CNT_W   = $clog2(STEPS);

   localparam logic [RAW_W-1:0]  RAW_TOP     = '1;
   localparam logic [GRAY_W-1:0] GRAY_TOP    = '1;
   localparam logic [RAW_W-1:0]  LOW_RESET   = RAW_W'(30000);
   localparam logic [RAW_W-1:0]  SPAN_RESET  = RAW_W'(2000);

   // register indexes on the csr port
   localparam logic CSR_LOW_LEVEL = 1'b0;
   localparam logic CSR_SPAN      = 1'b1;

   typedef struct packed {
      logic [RAW_W-1:0] pixel;
      logic             frame_end;
   } req_type;

   typedef struct packed {
      logic [GRAY_W-1:0] gray;
      logic [RAW_W-1:0]  frame_min;
      logic [RAW_W-1:0]  frame_max;
      logic              last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ src/twg_ctrl.sv @@
// sequencer: accept, eight divider steps, then hand-off to the output register
module twg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  twg_pkg::status_type status,
   output twg_pkg::cmd_type   cmd
);
   import twg_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_RUN:  cmd.step = 1'b1;
         ST_EMIT: cmd.emit = status.out_free;
         default: req_stall = 1'b1;
      endcase
   end

`ifndef SYNTHESIS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.emit}))
      else $error("more than one datapath command");
   a_load_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_RUN && cnt_ff == '0)
      else $error("load did not start the divider");
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && cnt_ff == CNT_W'(STEPS - 1) |=> state_ff == ST_EMIT)
      else $error("divider did not finish after its steps");
`endif

endmodule

@@ src/twg_dp.sv @@
// datapath: config registers, frame min/max, shift-subtract divider, output register
module twg_dp (
   input  logic               clock,
   input  logic               reset,
   input  twg_pkg::req_type   req_data,
   output twg_pkg::rsp_type   rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   input  twg_pkg::cmd_type   cmd,
   output twg_pkg::status_type status
);
   import twg_pkg::*;

   logic [RAW_W-1:0]  low_ff, span_ff;
   logic [RAW_W-1:0]  run_min_ff, run_max_ff;
   logic [RAW_W-1:0]  run_min_in, run_max_in;
   logic [RAW_W-1:0]  pend_min_ff, pend_max_ff;
   logic              pend_last_ff;
   logic [RAW_W-1:0]  rem_ff;
   logic [GRAY_W-1:0] quot_ff;
   logic              zero_ff, sat_ff;
   rsp_type           rsp_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [RAW_W-1:0]  span_eff;
   logic [RAW_W:0]    diff;
   logic              below;
   logic              over;
   logic [RAW_W:0]    rem2;
   logic              fits;
   logic [RAW_W:0]    rem_sub;
   logic [RAW_W-1:0]  new_min, new_max;

   assign span_eff = (span_ff == '0) ? RAW_W'(1) : span_ff;
   assign diff     = {1'b0, req_data.pixel} - {1'b0, low_ff};
   assign below    = diff[RAW_W] || (diff[RAW_W-1:0] == '0);
   assign over     = !below && (diff[RAW_W-1:0] >= span_eff);
   assign rem2     = {rem_ff, 1'b0};
   assign fits     = rem2 >= {1'b0, span_eff};
   assign rem_sub  = rem2 - {1'b0, span_eff};

   assign new_min = (req_data.pixel < run_min_ff) ? req_data.pixel : run_min_ff;
   assign new_max = (req_data.pixel > run_max_ff) ? req_data.pixel : run_max_ff;

   always_comb begin
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      if (cmd.load) begin
         run_min_in = req_data.frame_end ? RAW_TOP : new_min;
         run_max_in = req_data.frame_end ? '0 : new_max;
      end
   end

   // csr and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= LOW_RESET;
         span_ff    <= SPAN_RESET;
         run_min_ff <= RAW_TOP;
         run_max_ff <= '0;
      end else begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_LOW_LEVEL: low_ff  <= csr_data;
               CSR_SPAN:      span_ff <= csr_data;
               default:       low_ff  <= low_ff;
            endcase
         end
      end
   end

   // divider and pending report
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zero_ff      <= below;
         sat_ff       <= over;
         rem_ff       <= (below || over) ? '0 : diff[RAW_W-1:0];
         quot_ff      <= '0;
         pend_last_ff <= req_data.frame_end;
         pend_min_ff  <= req_data.frame_end ? new_min : '0;
         pend_max_ff  <= req_data.frame_end ? new_max : '0;
      end else if (cmd.step) begin
         rem_ff  <= fits ? rem_sub[RAW_W-1:0] : rem2[RAW_W-1:0];
         quot_ff <= {quot_ff[GRAY_W-2:0], fits};
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.gray      <= zero_ff ? '0 : (sat_ff ? GRAY_TOP : quot_ff);
         rsp_data_ff.frame_min <= pend_min_ff;
         rsp_data_ff.frame_max <= pend_max_ff;
         rsp_data_ff.last      <= pend_last_ff;
      end
   end

   assign rsp_data        = rsp_data_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> rem_ff < span_eff)
      else $error("divider remainder not below divisor");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit into a full output register");
   a_zero_gray: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && zero_ff |=> rsp_valid && rsp_data.gray == '0)
      else $error("pixel at or below level did not map to zero");
`endif

endmodule

@@ src/thermal_window_to_gray_top.sv @@
// top level of the thermal window to gray mapper
// Maps 16-bit raw thermal pixels to gray bytes, gray = (pixel - low_level) * 256 / span,
// truncated and clamped to 0..255 (span 0 acts as 1), and reports the frame minimum and
// maximum on the item flagged frame_end, then re-arms them. One item is worked at a time:
// after the accepting cycle it runs eight steps of the shared shift-subtract divider, then
// a hand-off state moves the result into the output register; no new item is accepted
// until that hand-off is done, and a stalled output holds the hand-off. The next item is
// accepted even while the previous result still waits in the output register. csr writes
// are taken every cycle (csr_ready is tied high) and should only be made while idle.
module thermal_window_to_gray_top (
   input  logic             clock,
   input  logic             reset,
   // input items
   input  logic             req_valid,
   output logic             req_stall,
   input  twg_pkg::req_type req_data,
   // result items
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output twg_pkg::rsp_type rsp_data,
   // register writes: index 0 low_level, index 1 span
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [15:0]      csr_data
);
   import twg_pkg::*;

   cmd_type    cmd;
   status_type status;

   // write port never back-pressures
   assign csr_ready = 1'b1;

   twg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // divider, min/max tracking and output register
   twg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

`ifndef SYNTHESIS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> cmd.load)
      else $error("accepted item not loaded");
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while busy");
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result not presented after emit");
`endif

endmodule
